[hdl/lcag_pkg.sv]
// Shared constants and command codes for the life grid block.
package lcag_pkg;

	localparam int unsigned MAX_SIZE   = 64;
	localparam int unsigned MIN_SIZE   = 3;
	localparam int unsigned ROW_W      = $clog2(MAX_SIZE);
	localparam int unsigned SIZE_W     = $clog2(MAX_SIZE + 1);
	localparam int unsigned CNT_W      = 4;

	// B3/S23 neighbor counts
	localparam logic [CNT_W-1:0] BIRTH_COUNT   = CNT_W'(3);
	localparam logic [CNT_W-1:0] SURVIVE_COUNT = CNT_W'(2);

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef logic [MAX_SIZE-1:0] row_word_t;

endpackage

[hdl/life_cellular_automaton_grid.sv]
// Top level of the toroidal Game of Life grid: sequencer, row buffers, cell store.
//
// Conway's Life (B3/S23) on a square torus of grid_size by grid_size cells
// (grid_size clamped to 3..64, reset 64), kept as one row-wide word per row
// in a single synchronous RAM of 64 rows by 64 bits. An item is taken when
// start is high and busy is low. A write or read keeps busy high in S_CELL:
// the row is read, then either written back with the one bit changed or,
// for a read, the bit is shown on alive_out with strobe high for exactly
// one cycle, both registered from the row data read out in S_CELL.
// The receiver cannot stall; a strobe that is missed is lost. Reads or
// writes outside the active square give alive_out 0 or are dropped; command
// 3 is accepted and does nothing. A step walks the rows through the RAM's
// single read port, one row per cycle, and computes a whole row of next
// states at once from three row buffers; each new row is written back in
// place once it is no longer needed as a neighbor, with row 0's old value
// kept aside for the last row. A step keeps busy high through S_STEP,
// S_DRAIN and S_LAST. The RAM has no clearing pass: a valid flop per
// row, cleared by reset, makes an unwritten row read as all dead. The
// sequencer never reads a row in the same cycle it writes it, so there is
// no forwarding path. grid_size is written through cfg_valid/cfg_ready,
// which only accepts while the block is idle.
module life_cellular_automaton_grid import lcag_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        command,
	input  logic [ROW_W-1:0]  row,
	input  logic [ROW_W-1:0]  column,
	input  logic              alive_in,
	// result
	output logic              strobe,
	output logic              alive_out,
	// configuration
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] grid_size
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CELL  = 5'b00010,  // row data back for a single-cell access
		S_STEP  = 5'b00100,  // issuing row reads 0..n
		S_DRAIN = 5'b01000,  // last read returns
		S_LAST  = 5'b10000   // final row, wraps onto saved row 0
	} state_t;

	state_t            state_q;
	logic [SIZE_W-1:0] n_q;        // clamped size in use
	logic [SIZE_W-1:0] k_q;        // read sequence index during a step
	logic [SIZE_W-1:0] k_s1;       // read sequence index of the row now at the RAM output
	logic              step_vld_s1;
	logic              rd_vld_s1;  // row valid bit alongside the RAM output
	logic [MAX_SIZE-1:0] row_vld_q;

	logic              strobe_q;
	logic              alive_out_q;

	cmd_t              cmd_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  col_q;
	logic              alive_q;
	logic              in_square_q;

	row_word_t         up_q, mid_q, row0_q;

	logic              accept;
	logic              in_square;
	logic [ROW_W-1:0]  n_m1;
	logic [ROW_W-1:0]  raddr;
	row_word_t         ram_rdata;
	row_word_t         rd_word;
	row_word_t         below;
	row_word_t         nxt_row;
	row_word_t         cell_word;
	logic              ram_we;
	logic [ROW_W-1:0]  waddr;
	row_word_t         wdata;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = !busy;
	assign strobe    = strobe_q;
	assign alive_out = alive_out_q;

	assign n_m1      = ROW_W'(n_q - SIZE_W'(1));
	assign in_square = ({1'b0, row} < n_q) && ({1'b0, column} < n_q);

	// unwritten rows read as dead
	assign rd_word = rd_vld_s1 ? ram_rdata : '0;
	assign below   = (state_q == S_LAST) ? row0_q : rd_word;

	always_comb begin
		cell_word         = rd_word;
		cell_word[col_q]  = alive_q;
	end

	// read address: the addressed row when idle, else the step sequence
	// n-1, 0, 1, ..., n-1
	always_comb begin
		raddr = row;
		if (state_q == S_STEP) begin
			raddr = (k_q == '0) ? n_m1 : ROW_W'(k_q - SIZE_W'(1));
		end
	end

	always_comb begin
		ram_we = 1'b0;
		waddr  = row_q;
		wdata  = nxt_row;
		case (state_q)
			S_CELL: begin
				ram_we = (cmd_q == CMD_WRITE) && in_square_q;
				waddr  = row_q;
				wdata  = cell_word;
			end
			S_STEP, S_DRAIN: begin
				// read k_s1 arriving completes row k_s1-2
				ram_we = step_vld_s1 && (k_s1 >= SIZE_W'(2));
				waddr  = ROW_W'(k_s1 - SIZE_W'(2));
			end
			S_LAST: begin
				ram_we = 1'b1;
				waddr  = n_m1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	lcag_row_rule u_rule (
		.up   (up_q),
		.mid  (mid_q),
		.dn   (below),
		.n_m1 (n_m1),
		.nxt  (nxt_row)
	);

	lcag_ram #(
		.DEPTH (MAX_SIZE),
		.WIDTH (MAX_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= SIZE_W'(MAX_SIZE);
			k_q         <= '0;
			k_s1        <= '0;
			step_vld_s1 <= 1'b0;
			rd_vld_s1   <= 1'b0;
			row_vld_q   <= '0;
			strobe_q    <= 1'b0;
		end else begin
			rd_vld_s1   <= row_vld_q[raddr];
			step_vld_s1 <= (state_q == S_STEP);
			k_s1        <= k_q;
			strobe_q    <= (state_q == S_CELL) && (cmd_q == CMD_READ);
			if (ram_we) begin
				row_vld_q[waddr] <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				if (grid_size < SIZE_W'(MIN_SIZE)) begin
					n_q <= SIZE_W'(MIN_SIZE);
				end else if (grid_size > SIZE_W'(MAX_SIZE)) begin
					n_q <= SIZE_W'(MAX_SIZE);
				end else begin
					n_q <= grid_size;
				end
			end
			case (state_q)
				S_IDLE: begin
					k_q <= '0;
					if (accept) begin
						case (command)
							CMD_WRITE, CMD_READ: state_q <= S_CELL;
							CMD_STEP:            state_q <= S_STEP;
							default:             state_q <= S_IDLE;
						endcase
					end
				end
				S_CELL: begin
					state_q <= S_IDLE;
				end
				S_STEP: begin
					k_q <= k_q + SIZE_W'(1);
					if (k_q == n_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_LAST;
				end
				S_LAST: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload and row buffers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= cmd_t'(command);
			row_q       <= row;
			col_q       <= column;
			alive_q     <= alive_in;
			in_square_q <= in_square;
		end
		if (state_q == S_CELL) begin
			alive_out_q <= in_square_q && rd_word[col_q];
		end
		if (step_vld_s1) begin
			if (k_s1 == '0) begin
				up_q <= rd_word;
			end else if (k_s1 == SIZE_W'(1)) begin
				mid_q  <= rd_word;
				row0_q <= rd_word;
			end else begin
				up_q  <= mid_q;
				mid_q <= rd_word;
			end
		end
	end

	// a result only follows a read access
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == S_CELL && cmd_q == CMD_READ))
		else $error("strobe without a read access");

	// the RAM is never written while idle
	a_no_idle_wr: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q != S_IDLE))
		else $error("RAM write while idle");

	// step writes stay inside the active square
	a_step_row: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != S_CELL) |-> ({1'b0, waddr} < n_q))
		else $error("step wrote a row outside the square");

	// read sequence index never runs past the size
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP) |-> (k_q <= n_q))
		else $error("step read index overran");

	// an accepted step enters the row walk
	a_step_go: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_STEP) |=> (state_q == S_STEP))
		else $error("step command not started");

endmodule

[hdl/lcag_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
module lcag_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/lcag_row_rule.sv]
// Next-generation row of B3/S23 with column wrap, one lane per column.
module lcag_row_rule import lcag_pkg::*; (
	input  row_word_t        up,
	input  row_word_t        mid,
	input  row_word_t        dn,
	input  logic [ROW_W-1:0] n_m1,
	output row_word_t        nxt
);

	for (genvar c = 0; c < MAX_SIZE; c++) begin : g_lane
		localparam int unsigned CL = (c + MAX_SIZE - 1) % MAX_SIZE;
		localparam int unsigned CR = (c + 1) % MAX_SIZE;

		logic             first_col;
		logic             last_col;
		logic             ul, ur, ml, mr, dl, dr;
		logic [CNT_W-1:0] cnt;
		logic             rule;

		assign first_col = (c == 0);
		assign last_col  = (n_m1 == ROW_W'(c));

		// left neighbor of column 0 is the last active column, and back
		assign ul = first_col ? up[n_m1]  : up[CL];
		assign ml = first_col ? mid[n_m1] : mid[CL];
		assign dl = first_col ? dn[n_m1]  : dn[CL];
		assign ur = last_col  ? up[0]     : up[CR];
		assign mr = last_col  ? mid[0]    : mid[CR];
		assign dr = last_col  ? dn[0]     : dn[CR];

		assign cnt = CNT_W'(ul) + CNT_W'(up[c]) + CNT_W'(ur)
		           + CNT_W'(ml) + CNT_W'(mr)
		           + CNT_W'(dl) + CNT_W'(dn[c]) + CNT_W'(dr);

		assign rule = (cnt == BIRTH_COUNT) || (mid[c] && (cnt == SURVIVE_COUNT));

		// columns past the active square keep their value
		assign nxt[c] = (ROW_W'(c) <= n_m1) ? rule : mid[c];
	end

endmodule
